>>> src/lkpi_pkg.sv
// Shared types, widths and helpers for the looped keyframe path interpolator.
// No dependencies; every other file in src imports this package.
package lkpi_pkg;

   // Table size and fixed-point format
   localparam int MAX_KEYFRAMES = 16;
   localparam int FRAC_BITS     = 16;
   localparam int IDX_W         = $clog2(MAX_KEYFRAMES);
   localparam int CFG_W         = 5;
   localparam int CNT_W         = IDX_W + 1;
   localparam int POS_W         = 32;
   localparam int DUR_W         = 32;
   localparam int TIME_W        = DUR_W + 1;
   localparam int TOT_W         = DUR_W + IDX_W;
   localparam int ALU_W         = TOT_W + 1;
   localparam int COEF_W        = FRAC_BITS + 1;
   localparam int PROD_W        = COEF_W + 1 + POS_W;
   localparam int STEP_W        = $clog2(TIME_W + 1);

   // Item kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // Fraction value 1.0
   localparam logic [COEF_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // Sequencer step marks
   localparam logic [STEP_W-1:0] MOD_LAST = STEP_W'(TIME_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(FRAC_BITS);
   localparam logic [STEP_W-1:0] MUL_X0   = STEP_W'(0);
   localparam logic [STEP_W-1:0] MUL_X1   = STEP_W'(1);
   localparam logic [STEP_W-1:0] MUL_Y0   = STEP_W'(2);
   localparam logic [STEP_W-1:0] MUL_Y1   = STEP_W'(3);
   localparam logic [STEP_W-1:0] MUL_OUT  = STEP_W'(4);

   typedef struct packed {
      logic                    kind;
      logic [DUR_W-1:0]        elapsed;
      logic [IDX_W-1:0]        entry_index;
      logic signed [POS_W-1:0] entry_x;
      logic signed [POS_W-1:0] entry_y;
      logic [DUR_W-1:0]        entry_duration;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [IDX_W-1:0]        segment;
   } rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [DUR_W-1:0]        dur;
   } kf_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_CMP,
      ST_MOD_DEC,
      ST_MOD_STEP,
      ST_MOD_INC,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_DIV,
      ST_MUL
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // Clamp the configured count into 1..MAX_KEYFRAMES
   function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] cfg);
      logic [CNT_W-1:0] c;
      if (cfg == '0) begin
         c = CNT_W'(1);
      end else if (int'(cfg) > MAX_KEYFRAMES) begin
         c = CNT_W'(MAX_KEYFRAMES);
      end else begin
         c = CNT_W'(cfg);
      end
      return c;
   endfunction

   // Next keyframe index, wrapping at the active count
   function automatic logic [IDX_W-1:0] next_seg(input logic [IDX_W-1:0] seg,
                                                 input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(seg) + CNT_W'(1);
      return (inc >= cnt) ? '0 : inc[IDX_W-1:0];
   endfunction

endpackage

>>> src/lkpi_alu.sv
// Shared add/subtract unit used for every time sum, compare and divide step.
// Depends on lkpi_pkg.
module lkpi_alu (
   input  lkpi_pkg::alu_op_type          op,
   input  logic [lkpi_pkg::ALU_W-1:0]    a,
   input  logic [lkpi_pkg::ALU_W-1:0]    b,
   output logic [lkpi_pkg::ALU_W-1:0]    res,
   output logic                          borrow
);
   import lkpi_pkg::*;

   logic [ALU_W:0] full;

   // Add or subtract with one extra bit; on subtract it flags a < b
   always_comb begin
      case (op)
         ALU_ADD: full = {1'b0, a} + {1'b0, b};
         ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default: full = {1'b0, a} + {1'b0, b};
      endcase
   end

   assign res    = full[ALU_W-1:0];
   assign borrow = (op == ALU_SUB) ? full[ALU_W] : 1'b0;

endmodule

>>> src/lkpi_mul.sv
// Registered fraction-by-position multiplier for the interpolation products.
// Depends on lkpi_pkg.
module lkpi_mul (
   input  logic                                clock,
   input  logic [lkpi_pkg::COEF_W-1:0]         coef,
   input  logic signed [lkpi_pkg::POS_W-1:0]   pos,
   output logic signed [lkpi_pkg::PROD_W-1:0]  prod
);
   import lkpi_pkg::*;

   logic signed [COEF_W:0]   coef_s;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   // Unsigned coefficient times signed position
   assign coef_s  = {1'b0, coef};
   assign prod_in = coef_s * pos;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> src/looped_keyframe_path_interpolator.sv
// Looped keyframe path interpolator: sequencer, keyframe table and datapath.
// A tick runs from accept to the result strobe through the sum of the active durations, the
// compare, the segment walk, the fraction divide and the multiplies; a tick that overruns a
// whole loop also runs the bit-serial modulo. One item at a time through the shared
// add/subtract unit. A load yields no result. Results are strobed for one cycle, no stall.
// Synchronous reset: count 1, accumulator and segment zero; table undefined until loaded.
module looped_keyframe_path_interpolator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  lkpi_pkg::req_type         req_data,
   output logic                      rsp_valid,
   output lkpi_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lkpi_pkg::CFG_W-1:0] csr_data
);
   import lkpi_pkg::*;

   // Keyframe table
   kf_type kf_mem [MAX_KEYFRAMES];
   kf_type rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   kf_type           wr_entry;

   // Control state
   state_type state_ff, state_in;
   logic [CFG_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]  seg_ff, seg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [TIME_W-1:0]       t_ff, t_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [ALU_W-1:0]        rem_ff, rem_in;
   logic [COEF_W-1:0]       quo_ff, quo_in;
   logic [DUR_W-1:0]        dur_ff, dur_in;
   logic signed [POS_W-1:0] x0_ff, x0_in;
   logic signed [POS_W-1:0] y0_ff, y0_in;
   logic signed [POS_W-1:0] px_ff, px_in;
   logic signed [PROD_W-1:0] sum_ff, sum_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Shared units
   alu_op_type        alu_op;
   logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
   logic              alu_borrow;
   logic [COEF_W-1:0] mul_coef;
   logic signed [POS_W-1:0]  mul_pos;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] sum_add;

   logic [CNT_W-1:0]  cnt_eff;
   logic [IDX_W-1:0]  seg_next;
   logic              sum_issue;
   logic              walk_gt;
   logic              walk_go;
   logic              tick_go;

   lkpi_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   lkpi_mul u_mul (
      .clock (clock),
      .coef  (mul_coef),
      .pos   (mul_pos),
      .prod  (prod)
   );

   // Common decodes
   assign cnt_eff   = eff_count(cnt_ff);
   assign seg_next  = next_seg(seg_ff, cnt_eff);
   assign sum_issue = (step_ff < STEP_W'(cnt_eff));
   assign walk_gt   = !alu_borrow && (alu_res != '0);
   assign walk_go   = walk_gt && (step_ff < STEP_W'(cnt_eff));
   assign tick_go   = start && (req_data.kind == KIND_TICK);
   assign sum_add   = sum_ff + prod;
   assign csr_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_go) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!sum_issue && !pend_ff) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = alu_borrow ? ST_MOD_DEC : ST_WALK_RD;
         end
         ST_MOD_DEC:  state_in = ST_MOD_STEP;
         ST_MOD_STEP: begin
            if (step_ff == '0) state_in = ST_MOD_INC;
         end
         ST_MOD_INC:  state_in = ST_WALK_RD;
         ST_WALK_RD:  state_in = ST_WALK_CMP;
         ST_WALK_CMP: begin
            state_in = walk_go ? ST_WALK_RD : ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == DIV_LAST) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (step_ff == MUL_OUT) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Unit operand select, table address and handshake outputs
   always_comb begin
      busy     = (state_ff != ST_IDLE);
      alu_op   = ALU_ADD;
      alu_a    = '0;
      alu_b    = '0;
      rd_addr  = seg_ff;
      mul_coef = FRAC_ONE - quo_ff;
      mul_pos  = x0_ff;
      mem_we   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            alu_a  = ALU_W'(acc_ff);
            alu_b  = ALU_W'(req_data.elapsed);
            mem_we = start && (req_data.kind == KIND_LOAD) &&
                     (int'(req_data.entry_index) < MAX_KEYFRAMES);
         end
         ST_SUM: begin
            alu_a   = ALU_W'(total_ff);
            alu_b   = ALU_W'(rd_ff.dur);
            rd_addr = step_ff[IDX_W-1:0];
         end
         ST_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(total_ff);
            alu_b  = ALU_W'(t_ff);
         end
         ST_MOD_DEC: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(t_ff);
            alu_b  = ALU_W'(1);
         end
         ST_MOD_STEP: begin
            alu_op = ALU_SUB;
            alu_a  = {rem_ff[ALU_W-2:0], t_ff[step_ff]};
            alu_b  = ALU_W'(total_ff);
         end
         ST_MOD_INC: begin
            alu_a = rem_ff;
            alu_b = ALU_W'(1);
         end
         ST_WALK_RD: begin
            rd_addr = seg_ff;
         end
         ST_WALK_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(t_ff);
            alu_b  = ALU_W'(rd_ff.dur);
         end
         ST_DIV: begin
            alu_op  = ALU_SUB;
            alu_a   = (step_ff == '0) ? rem_ff : {rem_ff[ALU_W-2:0], 1'b0};
            alu_b   = ALU_W'(dur_ff);
            rd_addr = seg_next;
         end
         ST_MUL: begin
            rd_addr = seg_next;
            case (step_ff)
               MUL_X0: begin
                  mul_coef = FRAC_ONE - quo_ff;
                  mul_pos  = x0_ff;
               end
               MUL_X1: begin
                  mul_coef = quo_ff;
                  mul_pos  = rd_ff.x;
               end
               MUL_Y0: begin
                  mul_coef = FRAC_ONE - quo_ff;
                  mul_pos  = y0_ff;
               end
               MUL_Y1: begin
                  mul_coef = quo_ff;
                  mul_pos  = rd_ff.y;
               end
               default: begin
                  mul_coef = quo_ff;
                  mul_pos  = rd_ff.y;
               end
            endcase
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      seg_in       = seg_ff;
      step_in      = step_ff;
      pend_in      = 1'b0;
      rsp_valid_in = 1'b0;
      t_in         = t_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dur_in       = dur_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      px_in        = px_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;

      // Take a register write
      if (csr_valid && csr_ready) cnt_in = csr_data;

      case (state_ff)
         ST_IDLE: begin
            // Start a tick: fold in elapsed time, drop a stale segment
            if (tick_go) begin
               t_in     = TIME_W'(alu_res);
               seg_in   = (CNT_W'(seg_ff) >= cnt_eff) ? '0 : seg_ff;
               total_in = '0;
               step_in  = '0;
            end
         end
         ST_SUM: begin
            // Issue one read per cycle, add the entry that arrived
            if (sum_issue) step_in = step_ff + STEP_W'(1);
            pend_in = sum_issue;
            if (pend_ff) total_in = TOT_W'(alu_res);
         end
         ST_CMP: begin
            step_in = '0;
         end
         ST_MOD_DEC: begin
            t_in    = TIME_W'(alu_res);
            rem_in  = '0;
            step_in = MOD_LAST;
         end
         ST_MOD_STEP: begin
            // Restoring remainder, one dividend bit per cycle
            rem_in = alu_borrow ? alu_a : alu_res;
            if (step_ff != '0) step_in = step_ff - STEP_W'(1);
         end
         ST_MOD_INC: begin
            t_in    = TIME_W'(alu_res);
            step_in = '0;
         end
         ST_WALK_CMP: begin
            // Advance while time exceeds the segment, else latch segment data
            if (walk_go) begin
               t_in    = TIME_W'(alu_res);
               seg_in  = seg_next;
               step_in = step_ff + STEP_W'(1);
            end else begin
               acc_in  = t_ff;
               dur_in  = rd_ff.dur;
               x0_in   = rd_ff.x;
               y0_in   = rd_ff.y;
               rem_in  = ALU_W'(t_ff);
               quo_in  = '0;
               step_in = '0;
            end
         end
         ST_DIV: begin
            // One fraction bit per cycle
            quo_in = {quo_ff[COEF_W-2:0], !alu_borrow};
            rem_in = alu_borrow ? alu_a : alu_res;
            step_in = (step_ff == DIV_LAST) ? '0 : step_ff + STEP_W'(1);
         end
         ST_MUL: begin
            // Accumulate the two weighted products per axis
            step_in = step_ff + STEP_W'(1);
            case (step_ff)
               MUL_X1: sum_in = prod;
               MUL_Y0: px_in  = sum_add[FRAC_BITS +: POS_W];
               MUL_Y1: sum_in = prod;
               MUL_OUT: begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.pos_x   = px_ff;
                  rsp_data_in.pos_y   = sum_add[FRAC_BITS +: POS_W];
                  rsp_data_in.segment = seg_ff;
                  step_in             = '0;
               end
               default: sum_in = sum_ff;
            endcase
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= CFG_W'(1);
         acc_ff       <= '0;
         seg_ff       <= '0;
         step_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         seg_ff       <= seg_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      total_ff    <= total_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dur_ff      <= dur_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      px_ff       <= px_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Keyframe table: zero duration is stored as one LSB
   always_comb begin
      wr_entry.x   = req_data.entry_x;
      wr_entry.y   = req_data.entry_y;
      wr_entry.dur = (req_data.entry_duration == '0) ? DUR_W'(1) : req_data.entry_duration;
   end

   always_ff @(posedge clock) begin
      if (mem_we) kf_mem[req_data.entry_index] <= wr_entry;
      rd_ff <= kf_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result only follows the last multiply step
   a_rsp_after_mul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_MUL)
      else $error("result strobe without a finished interpolation");

   // A load item never yields a result
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == KIND_LOAD) |=> !rsp_valid_ff)
      else $error("result strobe after a load item");

   // A tick item keeps the block busy
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == KIND_TICK) |=> busy)
      else $error("tick accepted but sequencer did not start");

   // Results are single-cycle strobes, never back to back
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

endmodule
